### hw/rtl/pfru_pkg.sv
`default_nettype none

package pfru_pkg;

	localparam int BYTE_W  = 8;
	localparam int FMT_W   = 4;
	localparam int DIM_W   = 13;
	localparam int PITCH_W = 15;
	localparam int ROW_W   = 12;
	localparam int HELD_W  = 24;
	localparam int ACT_W   = DIM_W + 2;
	localparam int CFG_W   = PITCH_W;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_PITCH_DEF = 16384;
	localparam int MAX_ROWS      = 4096;

	localparam logic [BYTE_W-1:0] FULL = 8'hFF;

	localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd1;
	localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd1;
	localparam logic [PITCH_W-1:0] RST_PITCH  = 15'd4;

	typedef enum logic [FMT_W-1:0] {
		FMT_ONE_ALPHA = 4'd0,
		FMT_ALPHA     = 4'd1,
		FMT_LUM       = 4'd2,
		FMT_RED       = 4'd3,
		FMT_LUM_ALPHA = 4'd4,
		FMT_RG        = 4'd5,
		FMT_RGB       = 4'd6,
		FMT_BGR       = 4'd7,
		FMT_BGRA      = 4'd8,
		FMT_RGBA      = 4'd9
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_FORMAT = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_ROW_PITCH    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
	} rgba_t;

	// bytes per pixel of a format
	function automatic logic [2:0] pfru_bpp(input fmt_t fmt);
		logic [2:0] n;
		unique case (fmt)
			FMT_ONE_ALPHA, FMT_ALPHA, FMT_LUM, FMT_RED: n = 3'd1;
			FMT_LUM_ALPHA, FMT_RG:                      n = 3'd2;
			FMT_RGB, FMT_BGR:                           n = 3'd3;
			default:                                    n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/pfru_if.sv
`default_nettype none

interface pfru_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface pfru_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       image_done;

	modport source (output valid, output red, output green, output blue, output alpha,
		output image_done, input ready);
	modport sink   (input valid, input red, input green, input blue, input alpha,
		input image_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/pfru_expand.sv
`default_nettype none

// Map the gathered channel bytes of one pixel onto RGBA, filling absent channels.
module pfru_expand
	import pfru_pkg::*;
(
	input  fmt_t                   fmt,
	input  logic [3:0][BYTE_W-1:0] v,
	output rgba_t                  px
);

	always_comb begin
		unique case (fmt)
			FMT_ONE_ALPHA: px = '{red: FULL, green: FULL, blue: FULL, alpha: v[0]};
			FMT_ALPHA:     px = '{red: '0, green: '0, blue: '0, alpha: v[0]};
			FMT_LUM:       px = '{red: v[0], green: v[0], blue: v[0], alpha: FULL};
			FMT_RED:       px = '{red: v[0], green: '0, blue: '0, alpha: FULL};
			FMT_LUM_ALPHA: px = '{red: v[0], green: v[0], blue: v[0], alpha: v[1]};
			FMT_RG:        px = '{red: v[0], green: v[1], blue: '0, alpha: FULL};
			FMT_RGB:       px = '{red: v[0], green: v[1], blue: v[2], alpha: FULL};
			FMT_BGR:       px = '{red: v[2], green: v[1], blue: v[0], alpha: FULL};
			FMT_BGRA:      px = '{red: v[2], green: v[1], blue: v[0], alpha: v[3]};
			default:       px = '{red: v[0], green: v[1], blue: v[2], alpha: v[3]};
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/pixel_format_to_rgba_unpacker_top.sv
// A pixel is offered on the output once the byte completing it has been taken into the
// input register and the pixel has then been loaded into the result register.
// Throughput: one byte per cycle sustained while the result register has room for each
// completing byte.
// A pixel waiting on the output does not stop padding or partial-pixel bytes.
// Reset (arst_n low, asynchronous): registers return to rgba, 1x1, pitch 4; counters
// and held bytes clear; no transaction is pending on either side.
`default_nettype none

module pixel_format_to_rgba_unpacker_top
	import pfru_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_PITCH = MAX_PITCH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	pfru_byte_if.sink                 bytes,
	pfru_pix_if.source                pixels
);

	// byte_in_row never reaches the pitch, so it needs clog2 of the largest pitch
	localparam int BIR_W = $clog2(MAX_PITCH);
	// common width for position and pitch comparisons
	localparam int CW = ((BIR_W > ACT_W) ? BIR_W : ACT_W) + 1;

	// Configuration registers
	logic [FMT_W-1:0]   pixel_format_q;
	logic [DIM_W-1:0]   image_width_q;
	logic [DIM_W-1:0]   image_height_q;
	logic [PITCH_W-1:0] row_pitch_q;

	// Position state
	logic [BIR_W-1:0]  bir_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        bip_q;
	logic [HELD_W-1:0] held_q;

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Result register
	logic              valid_s2;
	rgba_t             px_s2;
	logic              done_s2;

	fmt_t                   fmt;
	logic [2:0]             bpp;
	logic [DIM_W-1:0]       w_eff;
	logic [DIM_W-1:0]       h_eff;
	logic [CW-1:0]          pitch_eff;
	logic [ACT_W-1:0]       active;
	logic                   in_active;
	logic                   complete;
	logic                   emit;
	logic                   done;
	logic                   out_free;
	logic                   adv_s1;
	logic [CW-1:0]          bir_inc;
	logic [DIM_W-1:0]       row_inc;
	logic [3:0][BYTE_W-1:0] chan;
	rgba_t                  px;

	// ---------------------------------------------------------------
	// Configuration writes: take effect at once, state is left alone
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGBA;
			image_width_q  <= RST_WIDTH;
			image_height_q <= RST_HEIGHT;
			row_pitch_q    <= RST_PITCH;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_wdata[FMT_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[DIM_W-1:0];
				REG_ROW_PITCH:    row_pitch_q    <= cfg_wdata[PITCH_W-1:0];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Effective geometry: unused format codes read as rgba, sizes clamp
	// ---------------------------------------------------------------
	always_comb begin
		fmt = (pixel_format_q > FMT_W'(FMT_RGBA)) ? FMT_RGBA : fmt_t'(pixel_format_q);
		bpp = pfru_bpp(fmt);

		if (32'(image_width_q) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
		else                                w_eff = image_width_q;

		if (image_height_q == '0)                  h_eff = DIM_W'(1);
		else if (32'(image_height_q) > MAX_ROWS)   h_eff = DIM_W'(MAX_ROWS);
		else                                       h_eff = image_height_q;

		if (row_pitch_q == '0)                     pitch_eff = CW'(1);
		else if (CW'(row_pitch_q) > CW'(MAX_PITCH)) pitch_eff = CW'(MAX_PITCH);
		else                                       pitch_eff = CW'(row_pitch_q);

		// width times bytes per pixel, by shift and add
		unique case (bpp)
			3'd1:    active = ACT_W'(w_eff);
			3'd2:    active = {1'b0, w_eff, 1'b0};
			3'd3:    active = ACT_W'(w_eff) + {1'b0, w_eff, 1'b0};
			default: active = {w_eff, 2'b00};
		endcase
	end

	// ---------------------------------------------------------------
	// Per-byte decisions on the byte in the input register
	// ---------------------------------------------------------------
	assign in_active = CW'(bir_q) < CW'(active);
	assign complete  = ({1'b0, bip_q} + 3'd1) >= bpp;
	assign emit      = valid_s1 && in_active && complete;
	assign bir_inc   = CW'(bir_q) + CW'(1);
	assign row_inc   = DIM_W'(row_q) + DIM_W'(1);
	assign done      = emit && (bir_inc == CW'(active)) && (row_inc == h_eff);

	// Advance a padding or partial byte at once; a completing byte waits for
	// room in the result register.
	assign out_free = !valid_s2 || pixels.ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign bytes.ready = !valid_s1 || adv_s1;

	// Channel bytes: held bytes below, the current byte in the last slot
	always_comb begin
		chan[0] = held_q[7:0];
		chan[1] = held_q[15:8];
		chan[2] = held_q[23:16];
		chan[3] = '0;
		unique case (bpp)
			3'd1:    chan[0] = byte_s1;
			3'd2:    chan[1] = byte_s1;
			3'd3:    chan[2] = byte_s1;
			default: chan[3] = byte_s1;
		endcase
	end

	pfru_expand u_expand (
		.fmt (fmt),
		.v   (chan),
		.px  (px)
	);

	// ---------------------------------------------------------------
	// Input register: take a transaction whenever the stage empties
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	// ---------------------------------------------------------------
	// Row, pixel and held-byte state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q  <= '0;
			row_q  <= '0;
			bip_q  <= '0;
			held_q <= '0;
		end else if (adv_s1) begin
			if (done) begin
				// end of image: restart every counter
				bir_q  <= '0;
				row_q  <= '0;
				bip_q  <= '0;
				held_q <= '0;
			end else if (bir_inc >= pitch_eff) begin
				// end of row: drop any partial pixel, wrap the row counter
				bir_q  <= '0;
				bip_q  <= '0;
				held_q <= '0;
				row_q  <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				bir_q <= bir_inc[BIR_W-1:0];
				if (in_active) begin
					if (complete) begin
						bip_q  <= '0;
						held_q <= '0;
					end else begin
						held_q <= held_q | (HELD_W'(byte_s1) << {bip_q, 3'b000});
						bip_q  <= bip_q + 2'd1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register: hold until taken, load when a pixel completes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && emit) begin
			valid_s2 <= 1'b1;
		end else if (pixels.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			px_s2   <= px;
			done_s2 <= done;
		end
	end

	assign pixels.valid      = valid_s2;
	assign pixels.red        = px_s2.red;
	assign pixels.green      = px_s2.green;
	assign pixels.blue       = px_s2.blue;
	assign pixels.alpha      = px_s2.alpha;
	assign pixels.image_done = done_s2;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------

	// No partial pixel means no held bytes
	a_held_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(bip_q == 2'd0) |-> (held_q == '0))
		else $error("held bytes not clear at pixel start");

	// The flagged pixel restarts the image
	a_done_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && done) |=> (bir_q == '0 && row_q == '0 && bip_q == 2'd0))
		else $error("counters not cleared after last pixel");

	// A completing byte blocked by a full result register stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a stalled byte");

endmodule

`default_nettype wire

### test/tb_pixel_format_to_rgba_unpacker_top.sv
`timescale 1ns / 100ps

module tb_pixel_format_to_rgba_unpacker_top;
	import pfru_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	// A pixel passes through the input register and then the result register after its last byte.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_LIMIT   = 2000;
	localparam int unsigned RANDOM_SHARE  = 267;

	typedef struct packed {
		rgba_t colour;
		logic  last;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	pfru_byte_if byte_ch ();
	pfru_pix_if  pix_ch ();

	pixel_format_to_rgba_unpacker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.bytes     (byte_ch),
		.pixels    (pix_ch)
	);

	always #2 clk = ~clk;

	// Stimulus and expectations.
	logic [7:0]   raw_bytes [$];
	pixel_t       expected_pixels [$];
	int unsigned  bytes_pushed;
	int unsigned  bytes_accepted;
	int unsigned  mismatch_count;
	int unsigned  cycle_count;
	int unsigned  tx_idle_pct;
	int unsigned  rx_idle_pct;
	bit           byte_moved;

	// Shadow of the configuration registers, updated on the same edge as the block's.
	logic [FMT_W-1:0]   reg_format;
	logic [DIM_W-1:0]   reg_width;
	logic [DIM_W-1:0]   reg_height;
	logic [PITCH_W-1:0] reg_pitch;

	// Shadow of the unpacker's position in the image.
	int unsigned row_pos;
	int unsigned row_num;
	int unsigned pixel_pos;
	logic [23:0] held;

	function automatic int unsigned pixel_bytes(input fmt_t f);
		case (f)
			FMT_ONE_ALPHA, FMT_ALPHA, FMT_LUM, FMT_RED: return 1;
			FMT_LUM_ALPHA, FMT_RG:                      return 2;
			FMT_RGB, FMT_BGR:                           return 3;
			default:                                    return 4;
		endcase
	endfunction

	function automatic void clear_shadow();
		reg_format = FMT_RGBA;
		reg_width  = RST_WIDTH;
		reg_height = RST_HEIGHT;
		reg_pitch  = RST_PITCH;
		row_pos    = 0;
		row_num    = 0;
		pixel_pos  = 0;
		held       = '0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		case (reg_idx_t'(idx))
			REG_PIXEL_FORMAT: reg_format = value[FMT_W-1:0];
			REG_IMAGE_WIDTH:  reg_width  = value[DIM_W-1:0];
			REG_IMAGE_HEIGHT: reg_height = value[DIM_W-1:0];
			REG_ROW_PITCH:    reg_pitch  = value[PITCH_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the shadow by one accepted byte and queue the pixel it completes, if any.
	function automatic void expand_byte(input logic [7:0] b);
		fmt_t        f;
		int unsigned bpp;
		int unsigned w;
		int unsigned h;
		int unsigned pitch;
		int unsigned active;
		logic [7:0]  v [4];
		pixel_t      p;

		// Unused format codes behave as rgba; sizes clamp to what the block supports.
		f      = (reg_format > FMT_RGBA) ? FMT_RGBA : fmt_t'(reg_format);
		bpp    = pixel_bytes(f);
		w      = (reg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_width;
		h      = (reg_height == 0) ? 1 : ((reg_height > MAX_ROWS) ? MAX_ROWS : reg_height);
		pitch  = (reg_pitch == 0) ? 1 :
			((reg_pitch > MAX_PITCH_DEF) ? MAX_PITCH_DEF : reg_pitch);
		active = w * bpp;
		p      = '0;

		if (row_pos < active) begin
			// A pixel closes on the first byte that fills its last slot, even
			// if the format changed while earlier bytes were held.
			if (pixel_pos + 1 >= bpp) begin
				v[0] = held[7:0];
				v[1] = held[15:8];
				v[2] = held[23:16];
				v[3] = 8'h00;
				v[bpp-1] = b;
				case (f)
					FMT_ONE_ALPHA: p.colour = {FULL, FULL, FULL, v[0]};
					FMT_ALPHA:     p.colour = {8'h00, 8'h00, 8'h00, v[0]};
					FMT_LUM:       p.colour = {v[0], v[0], v[0], FULL};
					FMT_RED:       p.colour = {v[0], 8'h00, 8'h00, FULL};
					FMT_LUM_ALPHA: p.colour = {v[0], v[0], v[0], v[1]};
					FMT_RG:        p.colour = {v[0], v[1], 8'h00, FULL};
					FMT_RGB:       p.colour = {v[0], v[1], v[2], FULL};
					FMT_BGR:       p.colour = {v[2], v[1], v[0], FULL};
					FMT_BGRA:      p.colour = {v[2], v[1], v[0], v[3]};
					default:       p.colour = {v[0], v[1], v[2], v[3]};
				endcase
				p.last = (row_pos + 1 == active) && (row_num + 1 == h);
				expected_pixels.push_back(p);
				pixel_pos = 0;
				held      = '0;
			end else begin
				held      = 24'({8'h00, held} | (32'(b) << (8 * pixel_pos)));
				pixel_pos = (pixel_pos + 1) % 4;
			end
		end

		if (p.last) begin
			// End of image: start the next one from the top.
			row_pos   = 0;
			row_num   = 0;
			pixel_pos = 0;
			held      = '0;
		end else begin
			row_pos++;
			if (row_pos >= pitch) begin
				// Row ends at the pitch; a partial pixel is dropped here.
				row_pos   = 0;
				pixel_pos = 0;
				held      = '0;
				row_num   = (row_num + 1 >= h) ? 0 : row_num + 1;
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("error at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("pixel %02h%02h%02h%02h done %0b with none expected",
				pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.alpha, pix_ch.image_done));
		end else begin
			want = expected_pixels.pop_front();
			if (pix_ch.red !== want.colour.red)
				report_mismatch($sformatf("red %0d, want %0d", pix_ch.red, want.colour.red));
			if (pix_ch.green !== want.colour.green)
				report_mismatch($sformatf("green %0d, want %0d", pix_ch.green,
					want.colour.green));
			if (pix_ch.blue !== want.colour.blue)
				report_mismatch($sformatf("blue %0d, want %0d", pix_ch.blue,
					want.colour.blue));
			if (pix_ch.alpha !== want.colour.alpha)
				report_mismatch($sformatf("alpha %0d, want %0d", pix_ch.alpha,
					want.colour.alpha));
			if (pix_ch.image_done !== want.last)
				report_mismatch($sformatf("image_done %0b, want %0b", pix_ch.image_done,
					want.last));
		end
	endtask

	// Monitor: sample both channels and the register port on the rising edge.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pixel_format_to_rgba_unpacker_top: mismatch");
			$finish;
		end else begin
			byte_moved = 1'b0;
			if (arst_n) begin
				if (cfg_wr_en)
					apply_register(cfg_index, cfg_wdata);
				if (byte_ch.valid && byte_ch.ready) begin
					byte_moved = 1'b1;
					bytes_accepted++;
					expand_byte(byte_ch.data_byte);
				end
				if (pix_ch.valid && pix_ch.ready)
					check_pixel();
			end
		end
	end

	// Driver: change inputs on the falling edge only. Hold a byte until its
	// transaction completes, then either present the next one or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			pix_ch.ready  <= 1'b0;
		end else begin
			if (!byte_ch.valid || byte_moved) begin
				if (raw_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					byte_ch.data_byte <= raw_bytes.pop_front();
					byte_ch.valid     <= 1'b1;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
			pix_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic void feed_byte(input logic [7:0] b);
		raw_bytes.push_back(b);
		bytes_pushed++;
	endfunction

	function automatic logic [7:0] random_byte();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	// Wait until every byte has been taken and every pixel delivered, then let
	// any trailing padding byte clear the pipeline.
	task automatic wait_idle();
		int unsigned n;
		@(negedge clk);
		while (bytes_accepted != bytes_pushed)
			@(negedge clk);
		n = 0;
		while (expected_pixels.size() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		if (expected_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
			expected_pixels.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
	endtask

	// Reprogram all four registers once the block is idle; return on a rising
	// edge so that new bytes never race the driver.
	task automatic load_settings(input logic [FMT_W-1:0] fmt, input int unsigned w,
		input int unsigned h, input int unsigned pitch);
		wait_idle();
		write_register(REG_PIXEL_FORMAT, CFG_W'(fmt));
		write_register(REG_IMAGE_WIDTH, CFG_W'(w));
		write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
		write_register(REG_ROW_PITCH, CFG_W'(pitch));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One random setting followed mostly by whole images with random content,
	// sometimes by a truncated or oversized stream.
	task automatic random_phase(inout int unsigned fed);
		logic [FMT_W-1:0] fmt;
		int unsigned      bpp;
		int unsigned      w;
		int unsigned      h;
		int unsigned      pitch;
		int unsigned      active;
		int unsigned      rows;
		int unsigned      len;
		int unsigned      sel;
		bit               broken;

		wait_idle();
		// Realign to the start of an image after a broken stream: one byte at
		// 1x1 with pitch 1 clears every counter.
		if (row_pos != 0 || row_num != 0 || pixel_pos != 0) begin
			load_settings(FMT_LUM, 1, 1, 1);
			feed_byte(random_byte());
		end

		fmt    = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
		bpp    = pixel_bytes(fmt_t'(fmt));
		w      = $urandom_range(5, 1);
		h      = $urandom_range(3, 1);
		active = w * bpp;
		pitch  = active + $urandom_range(3);
		broken = 1'b0;
		sel    = $urandom_range(99);
		if (sel < 6) begin
			w      = 0;
			pitch  = $urandom_range(4);
			broken = 1'b1;
		end else if (sel < 12) begin
			h = 0;
		end else if (sel < 20) begin
			pitch  = $urandom_range(active - 1, 0);
			broken = 1'b1;
		end else if (sel < 25) begin
			w      = $urandom_range(1) ? 8191 : $urandom_range(8190, 4097);
			h      = $urandom_range(1) ? 8191 : $urandom_range(8190, 4097);
			pitch  = $urandom_range(1) ? 32767 : $urandom_range(32766, 16385);
			broken = 1'b1;
		end else if (sel < 35) begin
			broken = 1'b1;
		end

		rows = (h == 0) ? 1 : h;
		// The last row of an image carries no padding in the stream.
		len  = $urandom_range(3, 1) * ((rows - 1) * pitch + active);
		if (broken)
			len = $urandom_range(30, 1);

		load_settings(fmt, w, h, pitch);
		repeat (len) feed_byte(random_byte());
		fed += len;
	endtask

	initial begin
		int unsigned random_fed;
		int unsigned target;
		int          seg;

		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = 8'h00;
		pix_ch.ready      = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = REG_PIXEL_FORMAT;
		cfg_wdata         = '0;
		tx_idle_pct       = 7;
		rx_idle_pct       = 86;
		bytes_pushed      = 0;
		bytes_accepted    = 0;
		mismatch_count    = 0;
		cycle_count       = 0;
		random_fed        = 0;
		clear_shadow();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one rgba pixel, 1x1, pitch 4.
		feed_byte(8'h00); feed_byte(8'hFF); feed_byte(8'h5A); feed_byte(8'hA5);

		// One pixel in each single-byte format.
		load_settings(FMT_ONE_ALPHA, 1, 1, 1); feed_byte(8'hFF);
		load_settings(FMT_ALPHA, 1, 1, 1);     feed_byte(8'h00);
		load_settings(FMT_LUM, 1, 1, 1);       feed_byte(8'h80);
		load_settings(FMT_RED, 1, 1, 1);       feed_byte(8'h7F);

		// Two- and three-byte formats.
		load_settings(FMT_LUM_ALPHA, 1, 1, 2); feed_byte(8'h12); feed_byte(8'h34);
		load_settings(FMT_RG, 1, 1, 2);        feed_byte(8'h56); feed_byte(8'h78);
		load_settings(FMT_RGB, 1, 1, 3);
		feed_byte(8'h01); feed_byte(8'h02); feed_byte(8'h03);
		load_settings(FMT_BGR, 1, 1, 3);
		feed_byte(8'h01); feed_byte(8'h02); feed_byte(8'h03);

		// Four-byte: bgra, then an unused code which must behave as rgba.
		load_settings(FMT_BGRA, 1, 1, 4);
		feed_byte(8'h10); feed_byte(8'h20); feed_byte(8'h30); feed_byte(8'h40);
		load_settings(4'hF, 1, 1, 4);
		feed_byte(8'hC0); feed_byte(8'hFF); feed_byte(8'h00); feed_byte(8'h3C);

		// Zero width and zero pitch: pure padding, nothing comes out.
		load_settings(FMT_RGBA, 0, 1, 0);
		feed_byte(8'hAA); feed_byte(8'h55);

		// Zero height, pitch shorter than the active bytes of a row: the partial pixel at
		// the row end is dropped and the row counter wraps.
		load_settings(FMT_RG, 2, 0, 3);
		repeat (6) feed_byte(random_byte());

		// Change format with a pixel half held: rg closes on the next byte.
		load_settings(FMT_RGB, 2, 1, 6);
		feed_byte(8'hE1); feed_byte(8'hE2);
		load_settings(FMT_RG, 2, 1, 6);
		feed_byte(8'hE3); feed_byte(8'hE4); feed_byte(8'hE5);

		// Random part in three stretches: receiver slow, sender slow, neither.
		for (seg = 0; seg < 3; seg++) begin
			wait_idle();
			@(posedge clk);
			case (seg)
				0: begin tx_idle_pct = 7;  rx_idle_pct = 86; end
				1: begin tx_idle_pct = 86; rx_idle_pct = 7;  end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			target = random_fed + RANDOM_SHARE;
			while (random_fed < target)
				random_phase(random_fed);
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("pixel_format_to_rgba_unpacker_top: match");
		else
			$display("pixel_format_to_rgba_unpacker_top: mismatch");
		$finish;
	end

endmodule
